// ===== sv/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/biq_pkg.sv =====
package biq_pkg;

	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 32;
	localparam int COEF_FRAC = COEF_W - 4;
	localparam int NUM_COEFS = 5;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	// five products summed, exact
	localparam int ACC_W     = PROD_W + 3;
	localparam int RES_W     = ACC_W - COEF_FRAC;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = 3;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_word_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// register indexes
	localparam logic [IDX_W-1:0] REG_B0 = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_B1 = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_B2 = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_A1 = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_A2 = IDX_W'(4);

	// unity gain in Q4.28
	localparam coef_word_t COEF_ONE   = coef_word_t'(64'd1 << COEF_FRAC);
	localparam acc_t       ROUND_HALF = acc_t'(64'd1 << (COEF_FRAC - 1));
	localparam sample_t    SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t    SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	typedef struct packed {
		sample_t sample_in;
		logic    block_end;
	} in_req_t;

	typedef struct packed {
		sample_t sample_out;
		logic    block_end_out;
	} out_req_t;

	// one queued job: current input and its two predecessors
	typedef struct packed {
		sample_t x0;
		sample_t x1;
		sample_t x2;
		logic    block_end;
	} job_t;

	typedef struct packed {
		coef_word_t b0;
		coef_word_t b1;
		coef_word_t b2;
		coef_word_t a1;
		coef_word_t a2;
	} coef_set_t;

endpackage

// ===== sv/biquad_iir_filter_unit.sv =====
// second-order iir section, direct form i, q1.23 samples, q4.28 coefficients
// input channel: in_valid/in_ready with in_data (sample_in, block_end)
// output channel: out_valid/out_ready with out_data (sample_out, block_end_out)
// coefficients b0 b1 b2 a1 a2 sit at byte addresses 0x00 to 0x10 on the apb port,
//   already divided by a0; write them only while no request is in flight
// latency: a request accepted at one clock edge shows on out_valid after the
//   third edge that follows, when the output side is not stalled
// throughput: one request per cycle; the clock period is set by the output
//   stage loop (a1 times last output, three-way add, round and saturate)
// front end takes requests into a four-entry job queue and keeps the input history
// back end runs products, feedforward sum and the feedback stage in lockstep
// receiver stall: the output register holds its request, the back end freezes,
//   the queue keeps accepting until its four entries are full, then in_ready drops
// reset: histories cleared, b0 back to unity and the other coefficients to zero,
//   so the block passes samples through until programmed
// block_end rides along with its sample and does not touch the filter state
module biquad_iir_filter_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  biq_pkg::in_req_t            in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output biq_pkg::out_req_t           out_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [biq_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	biq_pkg::coef_set_t       coef_q;
	logic [biq_pkg::IDX_W-1:0] reg_idx;
	logic                     reg_wr;

	logic                     q_full;
	logic                     q_push;
	biq_pkg::job_t            q_in_job;
	logic                     q_pop;
	logic                     q_not_empty;
	biq_pkg::job_t            q_head_job;

	// register file, word addressed
	assign pready  = 1'b1;
	assign reg_idx = paddr[biq_pkg::ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= biq_pkg::COEF_ONE;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (reg_wr) begin
			unique case (reg_idx)
				biq_pkg::REG_B0: coef_q.b0 <= pwdata;
				biq_pkg::REG_B1: coef_q.b1 <= pwdata;
				biq_pkg::REG_B2: coef_q.b2 <= pwdata;
				biq_pkg::REG_A1: coef_q.a1 <= pwdata;
				biq_pkg::REG_A2: coef_q.a2 <= pwdata;
				default: ;  // unmapped addresses drop the write
			endcase
		end
	end

	// readback
	always_comb begin
		unique case (reg_idx)
			biq_pkg::REG_B0: prdata = coef_q.b0;
			biq_pkg::REG_B1: prdata = coef_q.b1;
			biq_pkg::REG_B2: prdata = coef_q.b2;
			biq_pkg::REG_A1: prdata = coef_q.a1;
			biq_pkg::REG_A2: prdata = coef_q.a2;
			default:         prdata = '0;
		endcase
	end

	// front: accept requests, attach input history
	biq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_in_job)
	);

	// decoupling queue between front and back
	biq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_in_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head_job  (q_head_job)
	);

	// back: multiply-accumulate, feedback, output register
	biq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.q_valid   (q_not_empty),
		.q_job     (q_head_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== sv/biq_front.sv =====
module biq_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  biq_pkg::in_req_t in_data,
	input  logic             q_full,
	output logic             q_push,
	output biq_pkg::job_t    q_job
);

	biq_pkg::sample_t x1_q;
	biq_pkg::sample_t x2_q;

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_job.x0        = in_data.sample_in;
		q_job.x1        = x1_q;
		q_job.x2        = x2_q;
		q_job.block_end = in_data.block_end;
	end

	// input history moves only on accepted requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
		end else if (q_push) begin
			x1_q <= in_data.sample_in;
			x2_q <= x1_q;
		end
	end

endmodule

// ===== sv/biq_queue.sv =====
module biq_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  biq_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output biq_pkg::job_t head_job
);

	biq_pkg::job_t                  mem_q [biq_pkg::Q_DEPTH];
	logic [biq_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [biq_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [biq_pkg::Q_PTR_W:0]      count_q;
	logic                           do_pop;

	assign full      = (count_q == (biq_pkg::Q_PTR_W+1)'(biq_pkg::Q_DEPTH));
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/biq_back.sv =====
module biq_back (
	input  logic               clk,
	input  logic               arst_n,
	input  biq_pkg::coef_set_t coef,
	input  logic               q_valid,
	input  biq_pkg::job_t      q_job,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output biq_pkg::out_req_t  out_data
);

	logic                 adv;
	logic                 fire;

	logic                 valid_s1;
	biq_pkg::prod_t       p0_s1;
	biq_pkg::prod_t       p1_s1;
	biq_pkg::prod_t       p2_s1;
	logic                 be_s1;

	logic                 valid_s2;
	biq_pkg::acc_t        ff_s2;
	logic                 be_s2;

	biq_pkg::sample_t     y1_q;
	biq_pkg::sample_t     y2_q;
	biq_pkg::prod_t       pa2_q;
	logic                 out_valid_q;
	biq_pkg::out_req_t    out_data_q;

	biq_pkg::prod_t       pa1;
	biq_pkg::acc_t        acc;
	logic [biq_pkg::RES_W-1:0] res;
	logic [biq_pkg::RES_W-biq_pkg::SAMPLE_W:0] res_top;
	biq_pkg::sample_t     y_new;

	// whole back pipeline moves together, frozen while the output is held
	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv;
	assign fire  = adv && valid_s2;

	// stage 1: feedforward products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p0_s1 <= coef.b0 * q_job.x0;
			p1_s1 <= coef.b1 * q_job.x1;
			p2_s1 <= coef.b2 * q_job.x2;
			be_s1 <= q_job.block_end;
		end
	end

	// stage 2: feedforward sum with rounding half folded in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ff_s2 <= biq_pkg::acc_t'(p0_s1) + biq_pkg::acc_t'(p1_s1)
				+ biq_pkg::acc_t'(p2_s1) + biq_pkg::ROUND_HALF;
			be_s2 <= be_s1;
		end
	end

	// output stage: feedback terms, round and saturate
	assign pa1     = coef.a1 * y1_q;
	assign acc     = ff_s2 - biq_pkg::acc_t'(pa2_q) - biq_pkg::acc_t'(pa1);
	assign res     = acc[biq_pkg::ACC_W-1:biq_pkg::COEF_FRAC];
	assign res_top = res[biq_pkg::RES_W-1:biq_pkg::SAMPLE_W-1];

	always_comb begin
		if ((&res_top) || !(|res_top)) begin
			y_new = res[biq_pkg::SAMPLE_W-1:0];
		end else if (res[biq_pkg::RES_W-1]) begin
			y_new = biq_pkg::SAMPLE_MIN;
		end else begin
			y_new = biq_pkg::SAMPLE_MAX;
		end
	end

	// a2 term is registered together with the second output history, so pa2_q holds a2 times y2_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y1_q        <= '0;
			y2_q        <= '0;
			pa2_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pa2_q <= coef.a2 * (fire ? y1_q : y2_q);
			if (adv) begin
				out_valid_q <= valid_s2;
			end
			if (fire) begin
				y1_q <= y_new;
				y2_q <= y1_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q.sample_out    <= y_new;
			out_data_q.block_end_out <= be_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== sv/biq_checker.sv =====
`include "assert_macros.svh"

module biq_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input biq_pkg::out_req_t           out_data,
	input logic                        psel,
	input logic                        penable,
	input logic                        pwrite,
	input logic [biq_pkg::ADDR_W-1:0]  paddr,
	input logic [31:0]                 pwdata,
	input logic [31:0]                 prdata,
	input logic                        pready
);

	logic       in_acc;
	logic       out_acc;
	logic       cfg_wr;
	logic [3:0] pending_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign cfg_wr  = psel && penable && pwrite && pready
		&& (paddr[biq_pkg::ADDR_W-1:2] < biq_pkg::IDX_W'(biq_pkg::NUM_COEFS));

	// requests taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {3'b000, in_acc} - {3'b000, out_acc};
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`ASSERT_IMPLY(a_no_invented, clk, arst_n, out_valid, pending_q != 4'd0)
	`ASSERT_IMPLY(a_bounded, clk, arst_n, 1'b1, pending_q <= 4'd7)
	`ASSERT_IMPLY(a_readback, clk, arst_n, cfg_wr ##1 (paddr == $past(paddr)), prdata == $past(pwdata))

endmodule

bind biquad_iir_filter_unit biq_checker u_biq_checker (.*);
